### src/assert_macros.svh
// Assertion macros shared by the sharpening filter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/shp_pkg.sv
// Shared constants and types of the 3x3 sharpening filter
`default_nettype none

package shp_pkg;

  // Line store sizing
  localparam int LINE_BYTES = 4096;
  localparam int LINE_AW    = $clog2(LINE_BYTES);

  // Field widths
  localparam int PIX_W      = 8;
  localparam int LEN_W      = 13;
  localparam int HEIGHT_W   = 16;
  localparam int ROW_W      = HEIGHT_W + 1;
  localparam int COEF_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Kernel arithmetic widths
  localparam int WIN_COLS   = 3;
  localparam int SUM_W      = PIX_W + 2;
  localparam int PROD_C_W   = COEF_W + PIX_W + 1;
  localparam int PROD_W     = COEF_W + SUM_W + 1;
  localparam int ACC_W      = PROD_W + 2;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_LENGTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_COEF_CENTER  = 3'd2,
    REG_COEF_EDGE    = 3'd3,
    REG_COEF_CORNER  = 3'd4
  } cfg_reg_t;

  typedef enum logic [0:0] {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  // One window column: older line, newer line, incoming byte
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

endpackage

`default_nettype wire

### src/shp_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module shp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port; read returns the contents before a same-cycle write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/shp_col_cell.sv
// One column cell of the 3x3 window: holds three bytes, takes its neighbour's on shift
`default_nettype none

module shp_col_cell
  import shp_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  col_t           col_in,
  output col_t           col,
  output logic [PIX_W:0] tb_sum
);

  // Advance the column by one place along the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift) begin
      col <= col_in;
    end
  end

  // Sum of the upper and lower bytes, shared by edge and corner terms
  assign tb_sum = {1'b0, col.top} + {1'b0, col.bot};

endmodule

`default_nettype wire

### src/sharpen_3x3_clamped_stream.sv
// Top level of the 3x3 sharpening filter over a raster-order byte stream
// Takes one byte per cycle and gives one result per cycle in steady state, while
// out_ready is high and input is not held off. Each accepted byte causes at most
// one result, for the byte one line plus one byte earlier in the stream; that
// result passes the line store read, window shift, multiply and clamp into the
// result queue before it leaves the block. Results wait in an eight-entry queue,
// and input is held off only while the queue together with the three work stages
// would hold eight results. Border bytes come out unchanged, interior bytes as the
// clamped kernel sum. At image end, send line_length + 1 flush commands to drain
// the pending results; the one flagged last_of_image closes the image. Registers
// may be written whenever no result is outstanding.
`default_nettype none
`include "assert_macros.svh"

module sharpen_3x3_clamped_stream
  import shp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  command,
  input  logic [PIX_W-1:0]      pixel_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      pixel_out,
  output logic                  last_of_image
);

  typedef struct packed {
    logic [LINE_AW-1:0] col;
    logic [LINE_AW-1:0] wrap_addr;
    logic [PIX_W-1:0]   pix;
    logic               emit;
    logic               interior;
    logic               last;
    logic               sel_wrap;
  } s1_t;

  typedef struct packed {
    logic             interior;
    logic             last;
    logic [PIX_W-1:0] border;
  } s2_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } res_t;

  // Configuration registers
  logic [LEN_W-1:0]         line_length;
  logic [HEIGHT_W-1:0]      image_height;
  logic signed [COEF_W-1:0] coef_center;
  logic signed [COEF_W-1:0] coef_edge;
  logic signed [COEF_W-1:0] coef_corner;

  // Position counters
  logic [LINE_AW-1:0] in_column, in_column_next;
  logic [ROW_W-1:0]   in_row, in_row_next;
  logic [LINE_AW-1:0] out_column, out_column_next;
  logic [ROW_W-1:0]   out_row, out_row_next;

  // Effective sizes
  logic [LINE_AW:0]    len;
  logic [LINE_AW-1:0]  len_m1;
  logic [HEIGHT_W-1:0] h;
  logic [HEIGHT_W-1:0] h_m1;

  // Accept stage
  logic               accept;
  logic               ignore;
  logic               in_img;
  logic               emit;
  logic               interior;
  logic               last;
  logic [LINE_AW-1:0] ic;
  logic [ROW_W-1:0]   ir;
  logic [LINE_AW-1:0] oc;
  logic [ROW_W-1:0]   orow;
  logic [LINE_AW:0]   ic_inc;
  logic [LINE_AW:0]   oc_inc;
  logic [PIX_W-1:0]   v;

  // Line store read stage
  logic               s1_valid;
  s1_t                s1;
  logic [PIX_W-1:0]   newer_rdata;
  logic [PIX_W-1:0]   older_a_rdata;
  logic [PIX_W-1:0]   older_b_rdata;
  logic               fwd_valid;
  logic [LINE_AW-1:0] fwd_addr;
  logic [PIX_W-1:0]   fwd_data;
  logic [PIX_W-1:0]   older_c;
  logic [PIX_W-1:0]   wrap_val;
  col_t               new_col;
  col_t               cols [WIN_COLS];
  col_t               cin [WIN_COLS];
  logic [PIX_W:0]     tb [WIN_COLS];

  // Multiply stage
  logic                       s2_valid;
  s2_t                        s2;
  logic [SUM_W-1:0]           sum_e;
  logic [SUM_W-1:0]           sum_c;
  logic signed [PROD_C_W-1:0] p_center;
  logic signed [PROD_W-1:0]   p_edge;
  logic signed [PROD_W-1:0]   p_corner;

  // Sum and clamp stage
  logic                       s3_valid;
  s2_t                        s3;
  logic signed [PROD_C_W-1:0] s3_center;
  logic signed [PROD_W-1:0]   s3_edge;
  logic signed [PROD_W-1:0]   s3_corner;
  logic signed [ACC_W-1:0]    total;
  logic [PIX_W-1:0]           clamped;
  res_t                       res;

  // Result queue
  res_t               fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head;
  logic [FIFO_AW-1:0] tail;
  logic [FIFO_AW:0]   count;
  logic [FIFO_AW+1:0] occ;
  logic               push;
  logic               pop;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length  <= LEN_W'(1920);
      image_height <= HEIGHT_W'(480);
      coef_center  <= COEF_W'(5);
      coef_edge    <= -COEF_W'(1);
      coef_corner  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LINE_LENGTH:  line_length  <= cfg_data[LEN_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
        REG_COEF_CENTER:  coef_center  <= $signed(cfg_data[COEF_W-1:0]);
        REG_COEF_EDGE:    coef_edge    <= $signed(cfg_data[COEF_W-1:0]);
        REG_COEF_CORNER:  coef_corner  <= $signed(cfg_data[COEF_W-1:0]);
        default: ;
      endcase
    end
  end

  // Limit line length and height to their working ranges
  always_comb begin
    if (line_length == '0) begin
      len = (LINE_AW+1)'(1);
    end else if (int'(line_length) > LINE_BYTES) begin
      len = (LINE_AW+1)'(LINE_BYTES);
    end else begin
      len = (LINE_AW+1)'(line_length);
    end
    len_m1 = LINE_AW'(len - (LINE_AW+1)'(1));
    h      = (image_height == '0) ? HEIGHT_W'(1) : image_height;
    h_m1   = h - HEIGHT_W'(1);
  end

  assign accept = in_valid && in_ready;

  // Decode the incoming item against the current positions
  always_comb begin
    if ({1'b0, in_column} >= len) begin
      ic = '0;
      ir = in_row + ROW_W'(1);
    end else begin
      ic = in_column;
      ir = in_row;
    end
    if ({1'b0, out_column} >= len) begin
      oc   = '0;
      orow = out_row + ROW_W'(1);
    end else begin
      oc   = out_column;
      orow = out_row;
    end
    in_img   = ir < ROW_W'(h);
    ignore   = (command == CMD_FLUSH) && in_img;
    v        = ((command == CMD_PIXEL) && in_img) ? pixel_in : '0;
    emit     = (ir >= ROW_W'(2)) || ((ir == ROW_W'(1)) && (ic != '0));
    ic_inc   = {1'b0, ic} + (LINE_AW+1)'(1);
    oc_inc   = {1'b0, oc} + (LINE_AW+1)'(1);
    interior = (orow != '0) && (({1'b0, orow} + (ROW_W+1)'(1)) < (ROW_W+1)'(h)) &&
               (oc != '0) && (oc_inc < len);
    last     = (orow > ROW_W'(h_m1)) || ((orow == ROW_W'(h_m1)) && (oc >= len_m1));
  end

  // Advance the input and result positions
  always_comb begin
    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    if (accept) begin
      in_column_next  = ic;
      in_row_next     = ir;
      out_column_next = oc;
      out_row_next    = orow;
      if (!ignore) begin
        if (ic_inc >= len) begin
          in_column_next = '0;
          in_row_next    = ir + ROW_W'(1);
        end else begin
          in_column_next = LINE_AW'(ic_inc);
        end
        if (emit) begin
          if (last) begin
            in_column_next  = '0;
            in_row_next     = '0;
            out_column_next = '0;
            out_row_next    = '0;
          end else if (oc_inc >= len) begin
            out_column_next = '0;
            out_row_next    = orow + ROW_W'(1);
          end else begin
            out_column_next = LINE_AW'(oc_inc);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

  // Line stores: newer written on transfer, older in the cycle after from newer's old byte
  shp_ram #(.WIDTH(PIX_W), .DEPTH(LINE_BYTES)) u_newer (
    .clk   (clk),
    .we    (accept && !ignore),
    .waddr (ic),
    .wdata (v),
    .re    (accept),
    .raddr (ic),
    .rdata (newer_rdata)
  );

  shp_ram #(.WIDTH(PIX_W), .DEPTH(LINE_BYTES)) u_older_a (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1.col),
    .wdata (newer_rdata),
    .re    (accept),
    .raddr (ic),
    .rdata (older_a_rdata)
  );

  shp_ram #(.WIDTH(PIX_W), .DEPTH(LINE_BYTES)) u_older_b (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1.col),
    .wdata (newer_rdata),
    .re    (accept),
    .raddr (len_m1),
    .rdata (older_b_rdata)
  );

  // Hand the decoded item to the read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s1_valid <= accept && !ignore;
      if (s1_valid) begin
        fwd_valid <= 1'b1;
      end
    end
    if (accept && !ignore) begin
      s1.col       <= ic;
      s1.wrap_addr <= len_m1;
      s1.pix       <= v;
      s1.emit      <= emit;
      s1.interior  <= interior;
      s1.last      <= last;
      s1.sel_wrap  <= (ic == '0);
    end
    if (s1_valid) begin
      fwd_addr <= s1.col;
      fwd_data <= newer_rdata;
    end
  end

  // Bypass the older store write that coincided with the read
  always_comb begin
    older_c  = (fwd_valid && (fwd_addr == s1.col)) ? fwd_data : older_a_rdata;
    wrap_val = (fwd_valid && (fwd_addr == s1.wrap_addr)) ? fwd_data : older_b_rdata;
    new_col  = '{top: older_c, mid: newer_rdata, bot: s1.pix};
  end

  // Window as a chain of column cells, newest column at the high end
  for (genvar k = 0; k < WIN_COLS; k++) begin : g_cell
    if (k == WIN_COLS - 1) begin : g_head
      assign cin[k] = new_col;
    end else begin : g_body
      assign cin[k] = cols[k+1];
    end
    shp_col_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .shift  (s1_valid),
      .col_in (cin[k]),
      .col    (cols[k]),
      .tb_sum (tb[k])
    );
  end

  // Capture control and the pass-through byte alongside the window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1.emit;
    end
    if (s1_valid) begin
      s2.interior <= s1.interior;
      s2.last     <= s1.last;
      s2.border   <= s1.sel_wrap ? wrap_val : cols[WIN_COLS-1].mid;
    end
  end

  // Weighted terms of the symmetric kernel
  always_comb begin
    sum_e    = SUM_W'(tb[1]) + SUM_W'(cols[0].mid) + SUM_W'(cols[2].mid);
    sum_c    = SUM_W'(tb[0]) + SUM_W'(tb[2]);
    p_center = coef_center * $signed({1'b0, cols[1].mid});
    p_edge   = coef_edge * $signed({1'b0, sum_e});
    p_corner = coef_corner * $signed({1'b0, sum_c});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    if (s2_valid) begin
      s3        <= s2;
      s3_center <= p_center;
      s3_edge   <= p_edge;
      s3_corner <= p_corner;
    end
  end

  // Sum the terms and clamp to the byte range
  always_comb begin
    total = ACC_W'(s3_center) + ACC_W'(s3_edge) + ACC_W'(s3_corner);
    if (total < 0) begin
      clamped = '0;
    end else if (total > ACC_W'(PIX_MAX)) begin
      clamped = PIX_MAX;
    end else begin
      clamped = total[PIX_W-1:0];
    end
    res.pixel = s3.interior ? clamped : s3.border;
    res.last  = s3.last;
  end

  // Result queue
  assign push      = s3_valid;
  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign pixel_out = fifo_mem[head].pixel;
  assign last_of_image = fifo_mem[head].last;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[tail] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + FIFO_AW'(1);
      end
      if (pop) begin
        head <= head + FIFO_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (FIFO_AW+1)'(1);
        2'b01:   count <= count - (FIFO_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  // Hold off input once queue and work stages could fill the queue
  assign occ = (FIFO_AW+2)'(count) + (FIFO_AW+2)'(s1_valid) +
               (FIFO_AW+2)'(s2_valid) + (FIFO_AW+2)'(s3_valid);
  assign in_ready = occ < (FIFO_AW+2)'(FIFO_DEPTH);

  `ASSERT_ALWAYS(a_occ_bound, occ <= (FIFO_AW+2)'(FIFO_DEPTH), "result slots overcommitted")
  `ASSERT_IMPL(a_push_room, push && !pop, count < (FIFO_AW+1)'(FIFO_DEPTH), "result queue overflow")
  `ASSERT_NEXT(a_ignore_idle, accept && ignore, !s1_valid, "early flush reached the window")
  `ASSERT_NEXT(a_last_restart, accept && !ignore && emit && last,
               in_column == '0 && in_row == '0 && out_column == '0 && out_row == '0,
               "counters not restarted after last byte")

endmodule

`default_nettype wire
